[rtl/cse_pkg.sv]
// Shared widths, constants and controller/datapath interface types for the cosine engine.
`timescale 1ns / 1ps
package cse_pkg;

  localparam int ElemW    = 16;
  localparam int DotW     = 47;
  localparam int SqW      = 46;
  localparam int SqInW    = 31;
  localparam int HalfW    = 24;
  localparam int OpW      = 2 * HalfW;
  localparam int ProdW    = 96;
  localparam int SrchW    = 126;
  localparam int RShift   = 32;
  localparam int QW       = 16;
  localparam int KW       = 4;
  localparam int CntW     = 4;

  localparam logic [SqW-1:0]  SqMax   = {SqW{1'b1}};
  localparam logic [DotW-1:0] DotMax  = {1'b0, {(DotW-1){1'b1}}};
  localparam logic [DotW-1:0] DotMin  = {1'b1, {(DotW-1){1'b0}}};
  localparam logic [QW-1:0]   QPosMax = {1'b0, {(QW-1){1'b1}}};

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic          acc;
    logic          snap;
    logic          mul_en;
    logic          mul_sel;
    logic [1:0]    mul_part;
    logic          cand_en;
    logic [KW-1:0] k;
    logic          test_en;
    logic          test_final;
    logic          out_load;
  } cmd_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic degen;
    logic out_busy;
  } status_t;

endpackage

[rtl/cse_datapath.sv]
// Accumulators, shared multiplier and bitwise quotient search of the cosine engine.
`timescale 1ns / 1ps
module cse_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic signed [cse_pkg::ElemW-1:0]  elem_a,
  input  logic signed [cse_pkg::ElemW-1:0]  elem_b,
  input  cse_pkg::cmd_t                     cmd,
  output cse_pkg::status_t                  status,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [cse_pkg::ElemW-1:0]  similarity,
  output logic                              degenerate
);
  import cse_pkg::*;

  logic signed [DotW-1:0] dot_acc;
  logic [SqW-1:0]         ssa;
  logic [SqW-1:0]         ssb;
  logic [SqW-1:0]         sa;
  logic [SqW-1:0]         sb;
  logic [DotW-1:0]        dmag;
  logic                   dneg;
  logic                   degen;
  logic [ProdW-1:0]       prod_p;
  logic [ProdW-1:0]       prod_r;
  logic [SrchW-1:0]       a_s;
  logic [SrchW-1:0]       b_s;
  logic [SrchW-1:0]       a_c;
  logic [SrchW-1:0]       b_c;
  logic [QW-1:0]          q;

  logic signed [2*ElemW-1:0] p_ab;
  logic signed [2*ElemW-1:0] p_aa;
  logic signed [2*ElemW-1:0] p_bb;
  logic signed [DotW:0]      dot_sum;
  logic [SqW:0]              sqa_sum;
  logic [SqW:0]              sqb_sum;
  logic [DotW-1:0]           dot_next;
  logic [SqW-1:0]            ssa_next;
  logic [SqW-1:0]            ssb_next;
  logic [OpW-1:0]            x_op;
  logic [OpW-1:0]            y_op;
  logic [HalfW-1:0]          x_half;
  logic [HalfW-1:0]          y_half;
  logic [OpW-1:0]            pp;
  logic [ProdW-1:0]          pp_sh;
  logic [SrchW-1:0]          p_ext;
  logic [SrchW-1:0]          r_ext;
  logic [SrchW-1:0]          lhs;
  logic                      pass;
  logic [ElemW-1:0]          sim_next;

  // Accumulate with saturation.
  always_comb begin
    p_ab    = elem_a * elem_b;
    p_aa    = elem_a * elem_a;
    p_bb    = elem_b * elem_b;
    dot_sum = (DotW+1)'(dot_acc) + (DotW+1)'(p_ab);
    sqa_sum = {1'b0, ssa} + (SqW+1)'(p_aa[SqInW-1:0]);
    sqb_sum = {1'b0, ssb} + (SqW+1)'(p_bb[SqInW-1:0]);
    if (dot_sum[DotW] != dot_sum[DotW-1]) begin
      dot_next = dot_sum[DotW] ? DotMin : DotMax;
    end else begin
      dot_next = dot_sum[DotW-1:0];
    end
    ssa_next = sqa_sum[SqW] ? SqMax : sqa_sum[SqW-1:0];
    ssb_next = sqb_sum[SqW] ? SqMax : sqb_sum[SqW-1:0];
  end

  // One 24x24 multiplier builds both wide products from four partial products each.
  always_comb begin
    x_op   = cmd.mul_sel ? OpW'(dmag) : OpW'(sa);
    y_op   = cmd.mul_sel ? OpW'(dmag) : OpW'(sb);
    x_half = cmd.mul_part[1] ? x_op[OpW-1:HalfW] : x_op[HalfW-1:0];
    y_half = cmd.mul_part[0] ? y_op[OpW-1:HalfW] : y_op[HalfW-1:0];
    pp     = OpW'(x_half) * OpW'(y_half);
    case (cmd.mul_part)
      2'b00:   pp_sh = ProdW'(pp);
      2'b11:   pp_sh = ProdW'(pp) << (2 * HalfW);
      default: pp_sh = ProdW'(pp) << HalfW;
    endcase
  end

  // The trial tests (2q-1)^2 * P <= 4 * dot^2 * 2^30, with a = q^2 P and b = q P.
  always_comb begin
    p_ext = SrchW'(prod_p);
    r_ext = SrchW'({prod_r, {RShift{1'b0}}});
    lhs   = (a_c << 2) - (b_c << 2) + p_ext;
    pass  = (lhs <= r_ext) && (!cmd.test_final || q == QPosMax);
  end

  always_comb begin
    if (degen) begin
      sim_next = '0;
    end else if (dneg) begin
      sim_next = ElemW'(-q);
    end else if (q > QPosMax) begin
      sim_next = QPosMax;
    end else begin
      sim_next = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_acc <= '0;
      ssa     <= '0;
      ssb     <= '0;
    end else if (cmd.snap) begin
      dot_acc <= '0;
      ssa     <= '0;
      ssb     <= '0;
    end else if (cmd.acc) begin
      dot_acc <= dot_next;
      ssa     <= ssa_next;
      ssb     <= ssb_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      sa     <= ssa;
      sb     <= ssb;
      dneg   <= dot_acc[DotW-1];
      dmag   <= dot_acc[DotW-1] ? DotW'(-dot_acc) : DotW'(dot_acc);
      degen  <= (ssa == '0) || (ssb == '0);
      prod_p <= '0;
      prod_r <= '0;
      a_s    <= '0;
      b_s    <= '0;
      q      <= '0;
    end else begin
      if (cmd.mul_en) begin
        if (cmd.mul_sel) begin
          prod_r <= prod_r + pp_sh;
        end else begin
          prod_p <= prod_p + pp_sh;
        end
      end
      if (cmd.cand_en) begin
        a_c <= a_s + (b_s << (cmd.k + 1'b1)) + (p_ext << {cmd.k, 1'b0});
        b_c <= b_s + (p_ext << cmd.k);
      end
      if (cmd.test_en && pass) begin
        a_s <= a_c;
        b_s <= b_c;
        q   <= q + (QW'(1) << cmd.k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      similarity <= sim_next;
      degenerate <= degen;
    end
  end

  assign status.degen    = (ssa == '0) || (ssb == '0);
  assign status.out_busy = out_valid && !out_ready;

`ifndef NO_ASSERTIONS
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> similarity == '0)
    else $error("degenerate result with nonzero similarity");
  a_snap_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.snap |=> dot_acc == '0 && ssa == '0 && ssb == '0)
    else $error("accumulators not cleared after snapshot");
  a_q_range: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> q <= (QPosMax + QW'(1)))
    else $error("quotient out of range");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !status.out_busy)
    else $error("result register overwritten while occupied");
`endif

endmodule

[rtl/cse_ctrl.sv]
// Sequencer that drives accumulation, the product steps and the quotient search.
`timescale 1ns / 1ps
module cse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              last_elem,
  output logic              in_ready,
  input  cse_pkg::status_t  status,
  output cse_pkg::cmd_t     cmd
);
  import cse_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSnap = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StCand = 3'd3;
  localparam logic [2:0] StTest = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  localparam logic [CntW-1:0] MulLast  = CntW'(7);
  localparam logic [CntW-1:0] StepLast = CntW'(QW - 1);

  logic [2:0]      state;
  logic [2:0]      state_next;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] cnt_next;

  assign in_ready = (state == StIdle);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.mul_sel  = cnt[2];
    cmd.mul_part = cnt[1:0];
    cmd.test_final = (cnt == StepLast);
    cmd.k = (cnt == StepLast) ? '0 : KW'(StepLast - cnt - CntW'(1));
    case (state)
      StIdle: begin
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (last_elem) begin
            state_next = StSnap;
          end
        end
      end
      StSnap: begin
        cmd.snap = 1'b1;
        cnt_next = '0;
        state_next = status.degen ? StDone : StMul;
      end
      StMul: begin
        cmd.mul_en = 1'b1;
        if (cnt == MulLast) begin
          cnt_next   = '0;
          state_next = StCand;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      StCand: begin
        cmd.cand_en = 1'b1;
        state_next  = StTest;
      end
      StTest: begin
        cmd.test_en = 1'b1;
        if (cnt == StepLast) begin
          state_next = StDone;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = StCand;
        end
      end
      StDone: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = StIdle;
        end
      end
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

[rtl/cosine_similarity_engine.sv]
// Top level of the streaming cosine similarity engine.
`timescale 1ns / 1ps
// The engine takes element pairs of two Q1.15 vectors, one word per cycle, and keeps a
// saturating dot product and two sums of squares. On the word marked last_elem it freezes
// those sums and computes round(|dot| * 2^15 / sqrt(ssa * ssb)) exactly: one shared 24x24
// multiplier forms ssa*ssb and dot^2, then a bitwise search settles the fifteen quotient
// bits, each in a candidate step and a test step, plus a final check for plus one. When a
// vector is all zero the search is skipped, similarity is 0 and degenerate is 1. Input
// stays stalled until the result is loaded into the output register; other words are
// taken at one per cycle, also while an earlier result waits in the output register.
// Positive results saturate at 32767.
module cosine_similarity_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [cse_pkg::ElemW-1:0]  elem_a,
  input  logic signed [cse_pkg::ElemW-1:0]  elem_b,
  input  logic                              last_elem,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [cse_pkg::ElemW-1:0]  similarity,
  output logic                              degenerate
);
  import cse_pkg::*;

  cmd_t    cmd;
  status_t status;

  cse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_elem (last_elem),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  cse_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .elem_a     (elem_a),
    .elem_b     (elem_b),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .similarity (similarity),
    .degenerate (degenerate)
  );

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the streaming cosine similarity engine.
`timescale 1ns / 1ps
module tb;
  import cse_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [ElemW-1:0] elem_a = '0;
  logic signed [ElemW-1:0] elem_b = '0;
  logic last_elem = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [ElemW-1:0] similarity;
  logic degenerate;

  cosine_similarity_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .elem_a(elem_a), .elem_b(elem_b), .last_elem(last_elem),
    .out_valid(out_valid), .out_ready(out_ready),
    .similarity(similarity), .degenerate(degenerate)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic signed [ElemW-1:0] sim;
    logic                    deg;
  } score_t;

  typedef struct {
    int   a;
    int   b;
    bit   last;
    bit   typed;
    int   sim;
    bit   deg;
  } pair_row_t;

  score_t score_q[$];
  int     err_count = 0;
  bit     no_idle = 1'b0;

  // Running sums mirrored in the testbench, Q2.30 units.
  logic signed [DotW-1:0] dot_sum;
  logic [SqW-1:0]         sq_sum_a;
  logic [SqW-1:0]         sq_sum_b;

  // Rounded |dot| * 2^15 / sqrt(ssa * ssb), capped at 32768, found by bisection on
  // (2q-1)^2 * ssa * ssb <= dot^2 * 2^32.
  function automatic int cosine_mag(logic [DotW-1:0] dmag, logic [SqW-1:0] sa,
                                    logic [SqW-1:0] sb);
    logic [159:0] norm_prod;
    logic [159:0] bound;
    logic [159:0] odd_sq;
    int lo;
    int hi;
    int q;
    norm_prod = 160'(sa) * 160'(sb);
    bound = (160'(dmag) * 160'(dmag)) << 32;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      q = (lo + hi + 1) / 2;
      odd_sq = 160'(2 * q - 1) * 160'(2 * q - 1);
      if (norm_prod * odd_sq <= bound) lo = q;
      else hi = q - 1;
    end
    return lo;
  endfunction

  // Accumulates one accepted word; returns 1 with the expected score on the last word.
  function automatic bit accumulate_pair(int a, int b, bit last, output score_t s);
    longint d;
    longint sq;
    longint dmax;
    logic [DotW-1:0] dmag;
    int m;
    dmax = (longint'(1) << 46) - 1;
    d = longint'(dot_sum) + longint'(a) * longint'(b);
    if (d > dmax) d = dmax;
    if (d < -dmax - 1) d = -dmax - 1;
    dot_sum = d[DotW-1:0];
    sq = longint'(sq_sum_a) + longint'(a) * longint'(a);
    sq_sum_a = (sq > dmax) ? SqMax : sq[SqW-1:0];
    sq = longint'(sq_sum_b) + longint'(b) * longint'(b);
    sq_sum_b = (sq > dmax) ? SqMax : sq[SqW-1:0];
    if (!last) return 1'b0;
    if (sq_sum_a == 0 || sq_sum_b == 0) begin
      s.sim = '0;
      s.deg = 1'b1;
    end else begin
      dmag = (d < 0) ? DotW'(-d) : DotW'(d);
      m = cosine_mag(dmag, sq_sum_a, sq_sum_b);
      if (d < 0) s.sim = ElemW'(-m);
      else s.sim = (m > 32767) ? QPosMax : ElemW'(m);
      s.deg = 1'b0;
    end
    dot_sum = '0;
    sq_sum_a = '0;
    sq_sum_b = '0;
    return 1'b1;
  endfunction

  // Presents one word after a random idle gap and waits for its handshake.
  task automatic send_pair(int a, int b, bit last, bit typed, int tsim, bit tdeg);
    score_t s;
    while (!no_idle && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    elem_a    <= ElemW'(a);
    elem_b    <= ElemW'(b);
    last_elem <= last;
    do @(posedge clk); while (!(in_valid && in_ready));
    if (accumulate_pair(a, b, last, s)) begin
      if (typed) begin
        s.sim = ElemW'(tsim);
        s.deg = tdeg;
      end
      score_q = {score_q, s};
    end
  endtask

  function automatic int rand_elem(int kind);
    case (kind)
      0: return int'($urandom_range(65535)) - 32768;
      1: return int'($urandom_range(15)) - 8;
      default: return ($urandom_range(1)) ? 32767 - int'($urandom_range(3))
                                          : -32768 + int'($urandom_range(3));
    endcase
  endfunction

  // Result side: check each accepted result, then pick the next ready level.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (score_q.size() == 0) begin
          $display("%0t: unexpected result sim=%0d deg=%0b", $time, similarity, degenerate);
          err_count++;
        end else begin
          if (similarity !== score_q[0].sim) begin
            $display("%0t: similarity expected %0d actual %0d",
                     $time, score_q[0].sim, similarity);
            err_count++;
          end
          if (degenerate !== score_q[0].deg) begin
            $display("%0t: degenerate expected %0b actual %0b",
                     $time, score_q[0].deg, degenerate);
            err_count++;
          end
          void'(score_q.pop_front());
        end
      end
      out_ready <= no_idle || ($urandom_range(99) >= 28);
    end
  end

  // Directed words: extremes, all-zero vectors and exact cancellation.
  pair_row_t pair_table [18] = '{
    '{0, 0, 1, 1, 0, 1},
    '{-32768, -32768, 1, 1, 32767, 0},
    '{-32768, 32767, 1, 1, -32768, 0},
    '{32767, 32767, 1, 1, 32767, 0},
    '{32767, -32768, 1, 0, 0, 0},
    '{5, 0, 1, 1, 0, 1},
    '{0, 7, 1, 1, 0, 1},
    '{1, 0, 0, 0, 0, 0},
    '{0, 1, 1, 1, 0, 0},
    '{1, 1, 0, 0, 0, 0},
    '{1, -1, 1, 1, 0, 0},
    '{-1, -1, 0, 0, 0, 0},
    '{100, 3, 0, 0, 0, 0},
    '{-7, 9000, 1, 0, 0, 0},
    '{21845, -10923, 0, 0, 0, 0},
    '{-1, 1, 1, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0},
    '{0, 0, 1, 1, 0, 1}
  };

  initial begin
    int sent;
    int len;
    int kind;
    int mode;
    int a;
    int b;
    dot_sum = '0;
    sq_sum_a = '0;
    sq_sum_b = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (pair_table[i])
      send_pair(pair_table[i].a, pair_table[i].b, pair_table[i].last,
                pair_table[i].typed, pair_table[i].sim, pair_table[i].deg);
    sent = 0;
    while (sent < 1050) begin
      no_idle = (sent >= 400 && sent < 550);
      len = ($urandom_range(9) == 0) ? int'($urandom_range(40, 9))
                                      : int'($urandom_range(8, 1));
      kind = $urandom_range(2);
      mode = $urandom_range(9);
      for (int k = 0; k < len; k++) begin
        a = rand_elem(kind);
        b = rand_elem(kind);
        // Some vectors are parallel, opposite or all zero on one side.
        if (mode == 0) b = a;
        else if (mode == 1) b = (a == -32768) ? 32767 : -a;
        else if (mode == 2) a = 0;
        else if (mode == 3) b = 0;
        send_pair(a, b, k == len - 1, 1'b0, 0, 1'b0);
        sent++;
      end
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;
    while (score_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
rtl/cse_pkg.sv
rtl/cse_datapath.sv
rtl/cse_ctrl.sv
rtl/cosine_similarity_engine.sv
tb/sv/tb.sv
